// File: rtl/ordered_list_engine_top_assert.svh
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OLL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list engine assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OLL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list engine assertion failed");

`endif

// File: rtl/oll_pkg.sv
// Shared types and constants of the ordered list engine.
package oll_pkg;

  localparam int OP_W             = 3;
  localparam int VALUE_W          = 32;
  localparam int INDEX_W          = 8;
  localparam int DATA_W           = 31;
  localparam int DEFAULT_CAPACITY = 64;
  localparam int DEFAULT_CNT_W    = $clog2(DEFAULT_CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/oll_if.sv
// Request and response channel interfaces of the ordered list engine.
interface oll_cmd_if;
  import oll_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]       index;

  modport source (output valid, output operation, output value, output index, input ready);
  modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

interface oll_rsp_if #(
  parameter int CNT_W = oll_pkg::DEFAULT_CNT_W
);
  import oll_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [DATA_W-1:0] data;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output ok, output data, output count, input ready);
  modport sink   (input valid, input ok, input data, input count, output ready);
endinterface

// File: rtl/oll_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module oll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/oll_ctrl.sv
// Sequencer of the ordered list engine: walks the entry memory and holds the result.
`include "ordered_list_engine_top_assert.svh"

module oll_ctrl #(
  parameter int CAPACITY = oll_pkg::DEFAULT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  oll_cmd_if.sink                   cmd,
  oll_rsp_if.source                 rsp,
  output logic                      ram_we,
  output logic [ADDR_W-1:0]         ram_waddr,
  output logic [oll_pkg::DATA_W-1:0] ram_wdata,
  output logic                      ram_re,
  output logic [ADDR_W-1:0]         ram_raddr,
  input  logic [oll_pkg::DATA_W-1:0] ram_rdata
);
  import oll_pkg::*;

  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  state_t            state, state_next;
  op_t               op_reg, op_next;
  logic [DATA_W-1:0] val_reg, val_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  i, i_next;
  logic [CNT_W-1:0]  w, w_next;
  logic [DATA_W-1:0] carry, carry_next;
  logic              placing, placing_next;
  logic              found, found_next;
  logic              res_ok, res_ok_next;
  logic [DATA_W-1:0] res_data, res_data_next;
  logic [CNT_W-1:0]  res_count, res_count_next;
  logic              out_valid, out_valid_next;
  logic              out_ok, out_ok_next;
  logic [DATA_W-1:0] out_data, out_data_next;
  logic [CNT_W-1:0]  out_count, out_count_next;

  logic              neg;
  logic [DATA_W-1:0] val_in;
  logic [CMP_W-1:0]  idx_cmp, cnt_cmp;
  logic              full;
  logic              in_range;
  logic              skip;
  logic [CNT_W-1:0]  i_plus;
  logic [CNT_W-1:0]  wr_pos;

  assign neg      = cmd.value[VALUE_W-1];
  assign val_in   = cmd.value[DATA_W-1:0];
  assign idx_cmp  = CMP_W'(cmd.index);
  assign cnt_cmp  = CMP_W'(count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign in_range = (i < count);
  assign i_plus   = i + 1'b1;
  assign skip     = (op_reg == OP_POP) ? (i == '0) : (ram_rdata == val_reg);

  // No request is taken while reset is held.
  assign cmd.ready = (state == ST_IDLE) && !rst;
  assign rsp.valid = out_valid;
  assign rsp.ok    = out_ok;
  assign rsp.data  = out_data;
  assign rsp.count = out_count;

  assign ram_waddr = wr_pos[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    op_reg    <= op_next;
    val_reg   <= val_next;
    i         <= i_next;
    w         <= w_next;
    carry     <= carry_next;
    placing   <= placing_next;
    found     <= found_next;
    res_ok    <= res_ok_next;
    res_data  <= res_data_next;
    res_count <= res_count_next;
    out_ok    <= out_ok_next;
    out_data  <= out_data_next;
    out_count <= out_count_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op_reg;
    val_next       = val_reg;
    count_next     = count;
    i_next         = i;
    w_next         = w;
    carry_next     = carry;
    placing_next   = placing;
    found_next     = found;
    res_ok_next    = res_ok;
    res_data_next  = res_data;
    res_count_next = res_count;
    out_valid_next = out_valid && !rsp.ready;
    out_ok_next    = out_ok;
    out_data_next  = out_data;
    out_count_next = out_count;
    ram_we         = 1'b0;
    wr_pos         = i;
    ram_wdata      = carry;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          op_next        = op_t'(cmd.operation);
          val_next       = val_in;
          i_next         = '0;
          w_next         = '0;
          carry_next     = val_in;
          placing_next   = 1'b0;
          found_next     = 1'b0;
          res_ok_next    = 1'b0;
          res_data_next  = '0;
          res_count_next = count;
          state_next     = ST_DONE;
          case (op_t'(cmd.operation))
            OP_PUSH: begin
              if (!neg && !full) begin
                ram_we         = 1'b1;
                wr_pos         = count;
                ram_wdata      = val_in;
                count_next     = count + 1'b1;
                res_ok_next    = 1'b1;
                res_count_next = count + 1'b1;
              end
            end
            OP_POP: begin
              if (count != '0) begin
                ram_re     = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_INSERT: begin
              if (!neg && !full) begin
                ram_re     = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_ERASE: begin
              if (!neg) begin
                ram_re     = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_READ: begin
              if (idx_cmp < cnt_cmp) begin
                ram_re     = 1'b1;
                ram_raddr  = idx_cmp[ADDR_W-1:0];
                state_next = ST_READ_WAIT;
              end
            end
            OP_CLEAR: begin
              count_next     = '0;
              res_ok_next    = 1'b1;
              res_count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ_WAIT: begin
        res_ok_next   = 1'b1;
        res_data_next = ram_rdata;
        state_next    = ST_DONE;
      end

      ST_SCAN: begin
        // Data of entry i is on the read port; fetch entry i+1 meanwhile.
        i_next    = i_plus;
        ram_re    = (i_plus < count);
        ram_raddr = i_plus[ADDR_W-1:0];
        if (op_reg == OP_INSERT) begin
          // Once the slot is found, every later entry moves down by one.
          if (!in_range || placing || (ram_rdata <= val_reg)) begin
            ram_we       = 1'b1;
            wr_pos       = i;
            ram_wdata    = carry;
            carry_next   = ram_rdata;
            placing_next = 1'b1;
          end
          if (!in_range) begin
            count_next     = count + 1'b1;
            res_ok_next    = 1'b1;
            res_count_next = count + 1'b1;
            state_next     = ST_DONE;
          end
        end else begin
          // Pop and erase compact the list, dropping the skipped entries.
          if (in_range) begin
            if (skip) begin
              found_next = 1'b1;
              if (op_reg == OP_POP) begin
                res_data_next = ram_rdata;
              end
            end else begin
              ram_we    = 1'b1;
              wr_pos    = w;
              ram_wdata = ram_rdata;
              w_next    = w + 1'b1;
            end
          end else begin
            count_next     = w;
            res_count_next = w;
            res_ok_next    = found;
            state_next     = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_ok_next    = res_ok;
          out_data_next  = res_data;
          out_count_next = res_count;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `OLL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `OLL_ASSERT_NOW(a_write_in_store, clk, rst, ram_we, wr_pos < CNT_W'(CAPACITY))
  `OLL_ASSERT_NOW(a_compact_behind, clk, rst, (state == ST_SCAN) && (op_reg != OP_INSERT), w <= i)
  `OLL_ASSERT_NEXT(a_count_hold_done, clk, rst, state == ST_DONE, $stable(count))

endmodule

// File: rtl/ordered_list_engine_top.sv
// Top level of the ordered list engine: sequencer plus entry memory.
//
//   Channel | Dir  | Payload                        | Moves
//   cmd     | sink | operation, value, index        | one request per operation
//   rsp     | src  | ok, data, count                | one response per request
//
// Push, clear and every rejected request go straight from the idle state to
// the done state; a read in range passes through the read-wait state first.
// Pop, insert and erase walk the list once through the single read port of
// the entry memory, one entry per cycle. Reset is synchronous and clears
// only the entry count, the control state and the response valid flag; the
// entry memory is never cleared, since only entries below the count are ever
// used, so no clearing pass follows reset. The response sits in an output
// register: a new request is accepted while it waits, and the engine stalls
// before delivering the next response until it is taken.
module ordered_list_engine_top #(
  parameter int CAPACITY = oll_pkg::DEFAULT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic      clk,
  input  logic      rst,
  oll_cmd_if.sink   cmd,
  oll_rsp_if.source rsp
);
  import oll_pkg::*;

  // Address width of the entry memory; one entry per list position.
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // The sequencer owns the count, the scan pointers and the response register.
  oll_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Entry memory: list position i lives at address i, head at address zero.
  // During a scan the write trails the read, so they never hit one address.
  oll_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (ADDR_W)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
